/* src/cwss_pkg.sv */
// ----------------------------------------------------------------------------
// cwss_pkg
// shared widths, register indexes and control structs of the window sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cwss_pkg;

	localparam int CWSS_PE_ROWS = 4;
	localparam int CWSS_PE_COLS = 4;

	localparam int SLOT_BITS   = 5;
	localparam int SLOT_COUNT  = 4;
	localparam int LSEL_W      = SLOT_BITS * SLOT_COUNT;
	localparam int POS_W       = 13;
	localparam int CNT_W       = 16;
	localparam int DIM_W       = 12;
	localparam int WIN_W       = 5;
	localparam int BND_W       = 15;
	localparam int ROT_W       = 3;
	localparam int REQ_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 56;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PASS_COUNT     = 3'd0,
		REG_PREFETCH_ITEMS = 3'd1,
		REG_WINDOW_ROWS    = 3'd2,
		REG_WINDOW_COLS    = 3'd3,
		REG_STEP_SIZE      = 3'd4,
		REG_IMAGE_ROWS     = 3'd5,
		REG_IMAGE_COLS     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic fire;
		logic start;
		logic prefetch;
		logic compute;
		logic step_h;
		logic step_v;
		logic finish;
	} cwss_cmd_t;

	typedef struct packed {
		logic fetch_done;
		logic req_any;
		logic col_wrap;
		logic row_wrap;
		logic pass_last;
	} cwss_stat_t;

endpackage

`default_nettype wire

/* src/conv_window_stride_sequencer.sv */
// ----------------------------------------------------------------------------
// conv_window_stride_sequencer
// convolution window and stride sequencer for a pe array with line memories
//
// usage:
//  - s_axis carries one controller tick per beat: start flag and the pe
//    stride request bits; m_axis returns one result beat per input beat
//  - cfg writes a register by index; always ready, write only while idle
//  - a result appears in the cycle after its input beat is taken; one beat per
//    cycle is sustained while the remainder unit is idle and results are taken
//  - every vertical step tick, and every window_rows write, starts the row
//    offset remainder unit: a setup state, then a bit-serial pass, so
//    s_axis_tready stays low after such a beat until the pass is over
//  - the single output register frees the input side: a new beat is taken
//    while the held result is being taken in the same cycle
//  - when the receiver stalls, the result is held and s_axis_tready drops
//  - reset: phase idle, counters and held fields zero, registers to defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module conv_window_stride_sequencer import cwss_pkg::*; #(
	parameter int PE_ROWS = CWSS_PE_ROWS,
	parameter int PE_COLS = CWSS_PE_COLS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// start_layer [0], pe_stride_bits [16:1], zero [23:17]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// stride_advance [0], compute_on [1], layer_finished [2],
	// line_read_enable [3], line_write_enable [4], data_reuse [5],
	// reuse_column [17:6], fresh_column [29:18], line_select_packed [49:30],
	// zero [55:50]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	cwss_cmd_t         cmd;
	cwss_stat_t        stat;
	logic              fire;
	logic              rot_valid;
	logic              out_valid_q;
	logic              stride_advance;
	logic              compute_on;
	logic              layer_finished;
	logic              line_read_enable;
	logic              line_write_enable;
	logic              data_reuse;
	logic [DIM_W-1:0]  reuse_column;
	logic [DIM_W-1:0]  fresh_column;
	logic [LSEL_W-1:0] line_select_packed;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = rot_valid && (!out_valid_q || m_axis_tready);
	assign fire          = s_axis_tvalid && s_axis_tready;

	cwss_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.start (s_axis_tdata[0]),
		.stat  (stat),
		.cmd   (cmd)
	);

	cwss_dp #(
		.PE_ROWS(PE_ROWS),
		.PE_COLS(PE_COLS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.pe_stride_bits    (s_axis_tdata[REQ_W:1]),
		.cmd               (cmd),
		.stat              (stat),
		.rot_valid         (rot_valid),
		.stride_advance    (stride_advance),
		.compute_on        (compute_on),
		.layer_finished    (layer_finished),
		.line_read_enable  (line_read_enable),
		.line_write_enable (line_write_enable),
		.data_reuse        (data_reuse),
		.reuse_column      (reuse_column),
		.fresh_column      (fresh_column),
		.line_select_packed(line_select_packed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		6'b0,
		line_select_packed,
		fresh_column,
		reuse_column,
		data_reuse,
		line_write_enable,
		line_read_enable,
		layer_finished,
		compute_on,
		stride_advance
	};

endmodule

`default_nettype wire

/* src/cwss_rowmod.sv */
// ----------------------------------------------------------------------------
// cwss_rowmod
// row offset unit: row_pos mod window_rows (the pe row count when window_rows
// is zero) by bit-serial division, then reduced at the pe row count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwss_rowmod import cwss_pkg::*; #(
	parameter int PE_ROWS = CWSS_PE_ROWS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             dirty,
	input  wire logic [POS_W-1:0] row_pos,
	input  wire logic [WIN_W-1:0] window_rows,
	output logic      [ROT_W-1:0] rot,
	output logic                  rot_valid
);

	localparam int ITER_W = $clog2(POS_W);
	localparam int FOLD_W = WIN_W + ROT_W + 1;
	localparam logic [WIN_W-1:0]  PE_DIV  = WIN_W'(PE_ROWS);
	localparam logic [FOLD_W-1:0] PE_FOLD = FOLD_W'(PE_ROWS);

	typedef enum logic [1:0] {
		M_IDLE,
		M_PEND,
		M_PASS
	} mstate_t;

	mstate_t             state_q;
	logic [WIN_W-1:0]    div_q;
	logic [POS_W-1:0]    dvd_q;
	logic [WIN_W-1:0]    rem_q;
	logic [ITER_W-1:0]   iter_q;
	logic [ROT_W-1:0]    rot_q;

	logic [WIN_W:0]      trial;
	logic [WIN_W:0]      diff;
	logic                ge;
	logic [WIN_W-1:0]    rem_nx;

	// small remainder reduced at the pe row count by shifted compare and subtract
	function automatic logic [ROT_W-1:0] fold_rows(input logic [WIN_W-1:0] x);
		logic [FOLD_W-1:0] r;
		r = FOLD_W'(x);
		for (int k = WIN_W - 1; k >= 0; k--) begin
			if (r >= (PE_FOLD << k)) begin
				r = r - (PE_FOLD << k);
			end
		end
		return r[ROT_W-1:0];
	endfunction

	assign trial  = {rem_q, dvd_q[POS_W-1]};
	assign diff   = trial - {1'b0, div_q};
	assign ge     = trial >= {1'b0, div_q};
	assign rem_nx = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			div_q   <= '0;
			dvd_q   <= '0;
			rem_q   <= '0;
			iter_q  <= '0;
			rot_q   <= '0;
		end else if (dirty) begin
			state_q <= M_PEND;
		end else begin
			case (state_q)
				M_PEND: begin
					dvd_q   <= row_pos;
					rem_q   <= '0;
					iter_q  <= ITER_W'(POS_W - 1);
					state_q <= M_PASS;
					if (window_rows == '0) begin
						div_q <= PE_DIV;
					end else begin
						div_q <= window_rows;
					end
				end
				M_PASS: begin
					rem_q  <= rem_nx;
					dvd_q  <= {dvd_q[POS_W-2:0], 1'b0};
					iter_q <= iter_q - 1'b1;
					if (iter_q == '0) begin
						rot_q   <= fold_rows(rem_nx);
						state_q <= M_IDLE;
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	assign rot       = rot_q;
	assign rot_valid = (state_q == M_IDLE);

endmodule

`default_nettype wire

/* src/cwss_ctrl.sv */
// ----------------------------------------------------------------------------
// cwss_ctrl
// phase state machine: prefetch, compute, horizontal and vertical steps, done
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwss_ctrl import cwss_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic       start,
	input  wire cwss_stat_t stat,
	output cwss_cmd_t       cmd
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PREFETCH,
		PH_COMPUTE,
		PH_STEP_H,
		PH_STEP_V,
		PH_DONE
	} phase_t;

	phase_t phase_q;
	phase_t cur;
	phase_t nxt;

	assign cur = start ? PH_PREFETCH : phase_q;

	always_comb begin
		cmd          = '0;
		cmd.fire     = fire;
		cmd.start    = start;
		cmd.prefetch = (cur == PH_PREFETCH);
		cmd.compute  = (cur == PH_COMPUTE);
		cmd.step_h   = (cur == PH_STEP_H);
		cmd.step_v   = (cur == PH_STEP_V);
		cmd.finish   = (cur == PH_DONE);
	end

	always_comb begin
		case (cur)
			PH_PREFETCH: nxt = stat.fetch_done ? PH_COMPUTE : PH_PREFETCH;
			PH_COMPUTE:  nxt = stat.req_any ? PH_STEP_H : PH_COMPUTE;
			PH_STEP_H:   nxt = stat.col_wrap ? PH_STEP_V : PH_COMPUTE;
			PH_STEP_V: begin
				if (!stat.row_wrap) begin
					nxt = PH_COMPUTE;
				end else if (stat.pass_last) begin
					nxt = PH_DONE;
				end else begin
					nxt = PH_PREFETCH;
				end
			end
			PH_DONE:     nxt = PH_DONE;
			default:     nxt = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (fire) begin
			phase_q <= nxt;
		end
	end

endmodule

`default_nettype wire

/* src/cwss_dp.sv */
// ----------------------------------------------------------------------------
// cwss_dp
// configuration registers, position and pass counters, held result fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwss_dp import cwss_pkg::*; #(
	parameter int PE_ROWS = CWSS_PE_ROWS,
	parameter int PE_COLS = CWSS_PE_COLS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [REQ_W-1:0]      pe_stride_bits,
	input  wire cwss_cmd_t             cmd,
	output cwss_stat_t                 stat,
	output logic                       rot_valid,
	output logic                       stride_advance,
	output logic                       compute_on,
	output logic                       layer_finished,
	output logic                       line_read_enable,
	output logic                       line_write_enable,
	output logic                       data_reuse,
	output logic [DIM_W-1:0]           reuse_column,
	output logic [DIM_W-1:0]           fresh_column,
	output logic [LSEL_W-1:0]          line_select_packed
);

	localparam int NREQ = (PE_ROWS * PE_COLS >= REQ_W) ? REQ_W : PE_ROWS * PE_COLS;

	logic [CNT_W-1:0]  pass_count_q;
	logic [CNT_W-1:0]  prefetch_q;
	logic [WIN_W-1:0]  win_rows_q;
	logic [WIN_W-1:0]  win_cols_q;
	logic [WIN_W-1:0]  step_q;
	logic [DIM_W-1:0]  img_rows_q;
	logic [DIM_W-1:0]  img_cols_q;

	logic [POS_W-1:0]  row_pos_q;
	logic [POS_W-1:0]  col_pos_q;
	logic [CNT_W-1:0]  passes_q;
	logic [CNT_W-1:0]  fetched_q;
	logic [1:0]        en_q;
	logic              reuse_q;
	logic [DIM_W-1:0]  col_reuse_q;
	logic [DIM_W-1:0]  col_fresh_q;
	logic [LSEL_W-1:0] lsel_q;
	logic              adv_q;
	logic              comp_q;
	logic              fin_q;

	logic [CNT_W-1:0]  fetch_inc;
	logic [CNT_W-1:0]  pass_inc;
	logic [POS_W-1:0]  col_next;
	logic [POS_W-1:0]  row_next;
	logic signed [BND_W-1:0] col_bound;
	logic signed [BND_W-1:0] row_bound;
	logic signed [BND_W-1:0] col_ext;
	logic signed [BND_W-1:0] row_ext;
	logic [LSEL_W-1:0] lsel_nx;
	logic [ROT_W-1:0]  rot;
	logic              mod_dirty;

	assign fetch_inc = (cmd.start ? '0 : fetched_q) + 1'b1;
	assign pass_inc  = passes_q + 1'b1;
	assign col_next  = col_pos_q + POS_W'(step_q);
	assign row_next  = row_pos_q + POS_W'(step_q);
	assign col_bound = BND_W'(img_cols_q) - BND_W'(win_cols_q) + BND_W'(1);
	assign row_bound = BND_W'(img_rows_q) - BND_W'(win_rows_q) + BND_W'(1);
	assign col_ext   = BND_W'(col_next);
	assign row_ext   = BND_W'(row_next);

	always_comb begin
		stat            = '0;
		stat.fetch_done = fetch_inc >= prefetch_q;
		stat.req_any    = |pe_stride_bits[NREQ-1:0];
		stat.col_wrap   = col_ext >= col_bound;
		stat.row_wrap   = row_ext >= row_bound;
		stat.pass_last  = pass_inc >= pass_count_q;
	end

	// slot i: (i + row offset) wrapped at the pe row count
	always_comb begin
		logic [WIN_W-1:0] v;
		lsel_nx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			v = WIN_W'(i) + WIN_W'(rot);
			if (v >= WIN_W'(PE_ROWS)) begin
				v = v - WIN_W'(PE_ROWS);
			end
			if (i < PE_ROWS) begin
				lsel_nx[i*SLOT_BITS +: SLOT_BITS] = v;
			end
		end
	end

	assign mod_dirty = (cmd.fire && cmd.step_v)
		|| (cfg_we && cfg_index == REG_WINDOW_ROWS);

	cwss_rowmod #(
		.PE_ROWS(PE_ROWS)
	) u_rowmod (
		.clk        (clk),
		.arst_n     (arst_n),
		.dirty      (mod_dirty),
		.row_pos    (row_pos_q),
		.window_rows(win_rows_q),
		.rot        (rot),
		.rot_valid  (rot_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q <= CNT_W'(1);
			prefetch_q   <= '0;
			win_rows_q   <= WIN_W'(3);
			win_cols_q   <= WIN_W'(3);
			step_q       <= WIN_W'(1);
			img_rows_q   <= DIM_W'(32);
			img_cols_q   <= DIM_W'(32);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PASS_COUNT:     pass_count_q <= cfg_data;
				REG_PREFETCH_ITEMS: prefetch_q   <= cfg_data;
				REG_WINDOW_ROWS:    win_rows_q   <= cfg_data[WIN_W-1:0];
				REG_WINDOW_COLS:    win_cols_q   <= cfg_data[WIN_W-1:0];
				REG_STEP_SIZE:      step_q       <= cfg_data[WIN_W-1:0];
				REG_IMAGE_ROWS:     img_rows_q   <= cfg_data[DIM_W-1:0];
				REG_IMAGE_COLS:     img_cols_q   <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q   <= '0;
			col_pos_q   <= '0;
			passes_q    <= '0;
			fetched_q   <= '0;
			en_q        <= '0;
			reuse_q     <= 1'b0;
			col_reuse_q <= '0;
			col_fresh_q <= '0;
			lsel_q      <= '0;
			adv_q       <= 1'b0;
			comp_q      <= 1'b0;
			fin_q       <= 1'b0;
		end else if (cmd.fire) begin
			adv_q  <= cmd.step_h | cmd.step_v;
			comp_q <= cmd.compute;
			fin_q  <= cmd.finish;
			if (cmd.start) begin
				passes_q  <= '0;
				fetched_q <= '0;
			end
			if (cmd.prefetch) begin
				en_q      <= 2'b10;
				fetched_q <= fetch_inc;
			end else if (cmd.compute) begin
				en_q   <= 2'b11;
				lsel_q <= lsel_nx;
			end else if (cmd.step_h) begin
				if (stat.col_wrap) begin
					col_pos_q <= '0;
				end else begin
					col_pos_q <= col_next;
					if (step_q < win_cols_q) begin
						reuse_q     <= 1'b1;
						col_reuse_q <= col_next[DIM_W-1:0];
					end else begin
						reuse_q     <= 1'b0;
						col_fresh_q <= col_next[DIM_W-1:0];
					end
				end
			end else if (cmd.step_v) begin
				if (stat.row_wrap) begin
					row_pos_q <= '0;
					passes_q  <= pass_inc;
					if (!stat.pass_last) begin
						fetched_q <= '0;
					end
				end else begin
					row_pos_q <= row_next;
					reuse_q   <= (step_q < win_rows_q);
				end
			end else begin
				en_q <= '0;
			end
		end
	end

	assign stride_advance     = adv_q;
	assign compute_on         = comp_q;
	assign layer_finished     = fin_q;
	assign line_read_enable   = en_q[0];
	assign line_write_enable  = en_q[1];
	assign data_reuse         = reuse_q;
	assign reuse_column       = col_reuse_q;
	assign fresh_column       = col_fresh_q;
	assign line_select_packed = lsel_q;

endmodule

`default_nettype wire

/* verif/conv_window_stride_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// conv_window_stride_sequencer_tb
// self-checking bench for the convolution window and stride sequencer
//
// Ticks go in as s_axis beats. Results come back as m_axis beats. Each result
// is checked field by field: the typed rows of the short directed table
// against fixed beats, all other beats against a predictor in the bench. The
// directed table runs first with the reset register values. Several register
// settings follow, each with random tick streams: mostly start-led passes with
// random stride requests. Both sides idle at random, but not in one stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv_window_stride_sequencer_tb;
	import cwss_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 40;
	localparam int REQ_BITS = CWSS_PE_ROWS * CWSS_PE_COLS;
	localparam logic [REQ_W-1:0] REQ_MASK = (REQ_BITS >= REQ_W) ? '1 : REQ_W'((1 << REQ_BITS) - 1);

	typedef enum logic [2:0] {
		SEQ_IDLE, SEQ_FETCH, SEQ_RUN, SEQ_HSTEP, SEQ_VSTEP, SEQ_DONE
	} seq_phase_t;

	// m_axis_tdata layout, msb first
	typedef struct packed {
		logic [5:0]        pad;
		logic [LSEL_W-1:0] line_select;
		logic [DIM_W-1:0]  fresh_col;
		logic [DIM_W-1:0]  reuse_col;
		logic              reuse;
		logic              wr_en;
		logic              rd_en;
		logic              finished;
		logic              compute;
		logic              advance;
	} result_t;

	typedef struct packed {
		logic             st;
		logic [REQ_W-1:0] bits;
		logic             typed;
		result_t          res;
	} tick_row_t;

	typedef struct packed {
		logic [15:0]      pass_cnt;
		logic [15:0]      prefetch;
		logic [WIN_W-1:0] wr;
		logic [WIN_W-1:0] wc;
		logic [WIN_W-1:0] step;
		logic [DIM_W-1:0] ir;
		logic [DIM_W-1:0] ic;
		logic [15:0]      items;
	} reg_set_t;

	localparam result_t R_FETCH = '{6'd0, 20'h0, 12'd0, 12'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
	localparam result_t R_RUN = '{6'd0, 20'h18820, 12'd0, 12'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
	localparam result_t R_STEP = '{6'd0, 20'h18820, 12'd0, 12'd1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	logic calm = 1'b0;
	int mismatches = 0;
	int quiet_cycles = 0;
	result_t pending_results[$];
	result_t got_beat, want_beat;

	// predictor registers and state
	logic [15:0] pass_limit, fetch_goal;
	logic [WIN_W-1:0] win_h, win_w, stride;
	logic [DIM_W-1:0] img_h, img_w;
	seq_phase_t seq_ph;
	logic [POS_W-1:0] row_at, col_at;
	logic [CNT_W-1:0] pass_no, fetch_no;
	logic [1:0] en_held;
	logic reuse_held;
	logic [DIM_W-1:0] rcol_held, fcol_held;
	logic [LSEL_W-1:0] sel_held;

	conv_window_stride_sequencer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [LSEL_W-1:0] rotated_select();
		logic [LSEL_W-1:0] sel;
		int base;
		sel = '0;
		base = (win_h == 0) ? int'(row_at) : int'(row_at) % int'(win_h);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (i < CWSS_PE_ROWS)
				sel[i*SLOT_BITS +: SLOT_BITS] = SLOT_BITS'((i + base) % CWSS_PE_ROWS);
		end
		return sel;
	endfunction

	function automatic result_t step_sequencer(input logic st, input logic [REQ_W-1:0] bits);
		result_t r;
		int bound;
		r = '0;
		if (st) begin
			pass_no = '0;
			fetch_no = '0;
			seq_ph = SEQ_FETCH;
		end
		case (seq_ph)
			SEQ_FETCH: begin
				en_held = 2'b10;
				fetch_no = fetch_no + 1'b1;
				if (fetch_no >= fetch_goal)
					seq_ph = SEQ_RUN;
			end
			SEQ_RUN: begin
				r.compute = 1'b1;
				en_held = 2'b11;
				sel_held = rotated_select();
				if ((bits & REQ_MASK) != '0)
					seq_ph = SEQ_HSTEP;
			end
			SEQ_HSTEP: begin
				bound = int'(img_w) - int'(win_w) + 1;
				r.advance = 1'b1;
				col_at = col_at + stride;
				if (int'(col_at) >= bound) begin
					col_at = '0;
					seq_ph = SEQ_VSTEP;
				end else begin
					if (stride < win_w) begin
						reuse_held = 1'b1;
						rcol_held = col_at[DIM_W-1:0];
					end else begin
						reuse_held = 1'b0;
						fcol_held = col_at[DIM_W-1:0];
					end
					seq_ph = SEQ_RUN;
				end
			end
			SEQ_VSTEP: begin
				bound = int'(img_h) - int'(win_h) + 1;
				r.advance = 1'b1;
				row_at = row_at + stride;
				if (int'(row_at) >= bound) begin
					row_at = '0;
					pass_no = pass_no + 1'b1;
					if (pass_no >= pass_limit) begin
						seq_ph = SEQ_DONE;
					end else begin
						fetch_no = '0;
						seq_ph = SEQ_FETCH;
					end
				end else begin
					reuse_held = (stride < win_h);
					seq_ph = SEQ_RUN;
				end
			end
			SEQ_DONE: begin
				r.finished = 1'b1;
				en_held = 2'b00;
			end
			default: begin
				en_held = 2'b00;
			end
		endcase
		r.rd_en = en_held[0];
		r.wr_en = en_held[1];
		r.reuse = reuse_held;
		r.reuse_col = rcol_held;
		r.fresh_col = fcol_held;
		r.line_select = sel_held;
		return r;
	endfunction

	task automatic put_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PASS_COUNT:     pass_limit = val;
			REG_PREFETCH_ITEMS: fetch_goal = val;
			REG_WINDOW_ROWS:    win_h = val[WIN_W-1:0];
			REG_WINDOW_COLS:    win_w = val[WIN_W-1:0];
			REG_STEP_SIZE:      stride = val[WIN_W-1:0];
			REG_IMAGE_ROWS:     img_h = val[DIM_W-1:0];
			REG_IMAGE_COLS:     img_w = val[DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input reg_set_t s);
		put_reg(REG_PASS_COUNT, s.pass_cnt);
		put_reg(REG_PREFETCH_ITEMS, s.prefetch);
		put_reg(REG_WINDOW_ROWS, 16'(s.wr));
		put_reg(REG_WINDOW_COLS, 16'(s.wc));
		put_reg(REG_STEP_SIZE, 16'(s.step));
		put_reg(REG_IMAGE_ROWS, 16'(s.ir));
		put_reg(REG_IMAGE_COLS, 16'(s.ic));
		cfg_valid <= 1'b0;
	endtask

	task automatic push_tick(input logic st, input logic [REQ_W-1:0] bits, input logic typed,
		input result_t typed_res);
		result_t r;
		while (!calm && $urandom_range(99) < 23) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, bits, st};
		r = step_sequencer(st, bits);
		pending_results.push_back(typed ? typed_res : r);
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_and_settle();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string fname, input int unsigned want_v,
		input int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", fname, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= 23);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_beat = result_t'(m_axis_tdata);
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation waiting");
				mismatches++;
			end else begin
				want_beat = pending_results.pop_front();
				check_field("stride_advance", want_beat.advance, got_beat.advance);
				check_field("compute_on", want_beat.compute, got_beat.compute);
				check_field("layer_finished", want_beat.finished, got_beat.finished);
				check_field("line_read_enable", want_beat.rd_en, got_beat.rd_en);
				check_field("line_write_enable", want_beat.wr_en, got_beat.wr_en);
				check_field("data_reuse", want_beat.reuse, got_beat.reuse);
				check_field("reuse_column", want_beat.reuse_col, got_beat.reuse_col);
				check_field("fresh_column", want_beat.fresh_col, got_beat.fresh_col);
				check_field("line_select_packed", want_beat.line_select,
					got_beat.line_select);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		tick_row_t dir_ticks [14];
		reg_set_t reg_sets [9];
		logic st, first;
		logic [REQ_W-1:0] bits;
		int n;

		dir_ticks = '{
			'{1'b0, 16'h0000, 1'b1, '0},
			'{1'b0, 16'hFFFF, 1'b1, '0},
			'{1'b1, 16'h0000, 1'b1, R_FETCH},
			'{1'b0, 16'h0000, 1'b1, R_RUN},
			'{1'b0, 16'h8000, 1'b1, R_RUN},
			'{1'b0, 16'h0000, 1'b1, R_STEP},
			'{1'b0, 16'h0001, 1'b0, '0},
			'{1'b0, 16'hFFFF, 1'b0, '0},
			'{1'b0, 16'h0000, 1'b0, '0},
			'{1'b1, 16'h0000, 1'b0, '0},
			'{1'b0, 16'h5555, 1'b0, '0},
			'{1'b0, 16'hAAAA, 1'b0, '0},
			'{1'b1, 16'hFFFF, 1'b0, '0},
			'{1'b0, 16'h1234, 1'b0, '0}
		};

		// pass, prefetch, window rows/cols, step, image rows/cols, ticks
		reg_sets = '{
			'{16'd2, 16'd3, 5'd3, 5'd3, 5'd1, 12'd6, 12'd7, 16'd300},
			'{16'd1, 16'd0, 5'd2, 5'd5, 5'd2, 12'd9, 12'd12, 16'd250},
			'{16'd3, 16'd1, 5'd4, 5'd2, 5'd3, 12'd10, 12'd8, 16'd250},
			'{16'd0, 16'd2, 5'd1, 5'd1, 5'd1, 12'd1, 12'd1, 16'd150},
			'{16'd2, 16'd0, 5'd31, 5'd31, 5'd31, 12'd4, 12'd5, 16'd150},
			'{16'd2, 16'd1, 5'd0, 5'd3, 5'd2, 12'd8, 12'd8, 16'd200},
			'{16'd65535, 16'd65535, 5'd31, 5'd31, 5'd31, 12'd4095, 12'd4095, 16'd60},
			'{16'd1, 16'd0, 5'd5, 5'd4, 5'd1, 12'd4095, 12'd1, 16'd200},
			'{16'd2, 16'd0, 5'd1, 5'd1, 5'd31, 12'd4095, 12'd4095, 16'd200}
		};

		pass_limit = 16'd1;
		fetch_goal = 16'd0;
		win_h = 5'd3;
		win_w = 5'd3;
		stride = 5'd1;
		img_h = 12'd32;
		img_w = 12'd32;
		seq_ph = SEQ_IDLE;
		row_at = '0;
		col_at = '0;
		pass_no = '0;
		fetch_no = '0;
		en_held = '0;
		reuse_held = 1'b0;
		rcol_held = '0;
		fcol_held = '0;
		sel_held = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_ticks[i])
			push_tick(dir_ticks[i].st, dir_ticks[i].bits, dir_ticks[i].typed, dir_ticks[i].res);
		s_axis_tvalid <= 1'b0;

		foreach (reg_sets[k]) begin
			drain_and_settle();
			calm <= (k == 2);
			load_settings(reg_sets[k]);
			n = 0;
			first = 1'b1;
			while (n < int'(reg_sets[k].items)) begin
				if (first)
					st = 1'b1;
				else if (seq_ph == SEQ_IDLE || seq_ph == SEQ_DONE)
					st = ($urandom_range(3) == 0);
				else
					st = ($urandom_range(79) == 0);
				first = 1'b0;
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: bits = REQ_W'($urandom);
					6, 7:             bits = '0;
					default:          bits = REQ_W'(1) << $urandom_range(REQ_W - 1);
				endcase
				if (st || (seq_ph != SEQ_IDLE && seq_ph != SEQ_DONE))
					n++;
				push_tick(st, bits, 1'b0, '0);
			end
			s_axis_tvalid <= 1'b0;
		end

		calm <= 1'b0;
		drain_and_settle();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* conv_window_stride_sequencer.f */
src/cwss_pkg.sv
src/cwss_rowmod.sv
src/cwss_ctrl.sv
src/cwss_dp.sv
src/conv_window_stride_sequencer.sv
verif/conv_window_stride_sequencer_tb.sv
